@@ rtl/reorder_table_collation_compare_unit_defines.svh @@
// ---------------------------------------------------------------------------
// reorder_table_collation_compare_unit_defines.svh
// assertion macros shared by the collation compare rtl
// ---------------------------------------------------------------------------
`ifndef REORDER_TABLE_COLLATION_COMPARE_UNIT_DEFINES_SVH
`define REORDER_TABLE_COLLATION_COMPARE_UNIT_DEFINES_SVH

// same-cycle implication on i_clk, quiet while reset is held
`define RTCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, quiet while reset is held
`define RTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rtcc_pkg.sv @@
// ---------------------------------------------------------------------------
// rtcc_pkg
// shared types and codes of the collation compare unit
// ---------------------------------------------------------------------------
package rtcc_pkg;

    localparam int CODE_W         = 21;
    localparam int WINDOW_ENTRIES = 1024;
    localparam int EPOCH_W        = 8;

    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [2:0]         t_action;
    typedef logic [2:0]         t_status;
    typedef logic [EPOCH_W-1:0] t_epoch;

    // action codes
    localparam t_action ACT_COMPARE    = 3'd0;
    localparam t_action ACT_WRITE      = 3'd1;
    localparam t_action ACT_SET_WINDOW = 3'd2;
    localparam t_action ACT_DISABLE    = 3'd3;
    localparam t_action ACT_PRESET     = 3'd4;

    // status codes
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_LESS    = 3'd1;
    localparam t_status ST_GREATER = 3'd2;
    localparam t_status ST_EQUAL   = 3'd3;
    localparam t_status ST_RANGE   = 3'd4;

    // epoch zero marks a cleared entry, live epochs run from first to max
    localparam t_epoch EPOCH_NONE  = '0;
    localparam t_epoch EPOCH_FIRST = t_epoch'(1);
    localparam t_epoch EPOCH_MAX   = '1;

    typedef struct packed {
        t_epoch tag;
        t_code  value;
    } t_entry;

    typedef struct packed {
        logic   active;
        logic   preset;
        t_epoch epoch;
    } t_map_ctl;

endpackage

@@ rtl/rtcc_table.sv @@
// ---------------------------------------------------------------------------
// rtcc_table
// remap table memory: one write port, two registered read ports, clear sweep
// ---------------------------------------------------------------------------
module rtcc_table #(
    parameter int WINDOW_ENTRIES = rtcc_pkg::WINDOW_ENTRIES,
    localparam int IDX_W = $clog2(WINDOW_ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear_req,
    output logic                 o_busy,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  rtcc_pkg::t_entry     i_wr_entry,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx_a,
    input  logic [IDX_W-1:0]     i_rd_idx_b,
    output rtcc_pkg::t_entry     o_rd_a,
    output rtcc_pkg::t_entry     o_rd_b
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_ENTRIES - 1);

    rtcc_pkg::t_entry mem [WINDOW_ENTRIES];

    logic             r_busy;
    logic [IDX_W-1:0] r_clr_idx;
    rtcc_pkg::t_entry r_rd_a;
    rtcc_pkg::t_entry r_rd_b;

    // clear sweep runs after reset and on request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end else if (i_clear_req) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_idx] <= '{tag: rtcc_pkg::EPOCH_NONE, value: '0};
        end else if (i_we) begin
            mem[i_wr_idx] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= mem[i_rd_idx_a];
            r_rd_b <= mem[i_rd_idx_b];
        end
    end

    assign o_busy = r_busy;
    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ rtl/rtcc_map.sv @@
// ---------------------------------------------------------------------------
// rtcc_map
// maps one character code through the window, table entry or preset
// ---------------------------------------------------------------------------
module rtcc_map #(
    parameter int WINDOW_ENTRIES = rtcc_pkg::WINDOW_ENTRIES,
    localparam int IDX_W = $clog2(WINDOW_ENTRIES),
    localparam int BLK_W = rtcc_pkg::CODE_W - IDX_W
) (
    input  rtcc_pkg::t_code    i_code,
    input  rtcc_pkg::t_map_ctl i_ctl,
    input  logic [BLK_W-1:0]   i_block,
    input  rtcc_pkg::t_entry   i_rd,
    input  logic               i_byp_en,
    input  rtcc_pkg::t_entry   i_byp,
    output rtcc_pkg::t_code    o_mapped
);

    localparam rtcc_pkg::t_code CH_A     = 21'd65;
    localparam rtcc_pkg::t_code CH_C     = 21'd67;
    localparam rtcc_pkg::t_code CH_E     = 21'd69;
    localparam rtcc_pkg::t_code CH_I     = 21'd73;
    localparam rtcc_pkg::t_code CH_N     = 21'd78;
    localparam rtcc_pkg::t_code CH_O     = 21'd79;
    localparam rtcc_pkg::t_code CH_U     = 21'd85;
    localparam rtcc_pkg::t_code CH_Y     = 21'd89;
    localparam rtcc_pkg::t_code CH_LOW_Y = 21'd121;
    localparam rtcc_pkg::t_code CASE_OFS = 21'd32;
    localparam rtcc_pkg::t_code A_LO     = 21'd192;
    localparam rtcc_pkg::t_code A_HI     = 21'd198;
    localparam rtcc_pkg::t_code C_CED    = 21'd199;
    localparam rtcc_pkg::t_code E_LO     = 21'd200;
    localparam rtcc_pkg::t_code E_HI     = 21'd203;
    localparam rtcc_pkg::t_code I_LO     = 21'd204;
    localparam rtcc_pkg::t_code I_HI     = 21'd207;
    localparam rtcc_pkg::t_code N_TIL    = 21'd209;
    localparam rtcc_pkg::t_code O_LO     = 21'd210;
    localparam rtcc_pkg::t_code O_HI     = 21'd214;
    localparam rtcc_pkg::t_code U_LO     = 21'd217;
    localparam rtcc_pkg::t_code U_HI     = 21'd220;
    localparam rtcc_pkg::t_code Y_ACU    = 21'd221;
    localparam rtcc_pkg::t_code LOW_LO   = 21'd224;
    localparam rtcc_pkg::t_code LOW_HI   = 21'd253;
    localparam rtcc_pkg::t_code Y_DIA    = 21'd255;

    // latin-1 accent folding
    function automatic rtcc_pkg::t_code f_preset(input rtcc_pkg::t_code c);
        rtcc_pkg::t_code base;
        rtcc_pkg::t_code up;
        rtcc_pkg::t_code res;
        logic            hit;
        base = c;
        up   = c;
        hit  = 1'b1;
        if (c >= LOW_LO && c <= LOW_HI) begin
            base = c - CASE_OFS;
        end
        priority if (base >= A_LO && base <= A_HI) up = CH_A;
        else if (base == C_CED)                    up = CH_C;
        else if (base >= E_LO && base <= E_HI)     up = CH_E;
        else if (base >= I_LO && base <= I_HI)     up = CH_I;
        else if (base == N_TIL)                    up = CH_N;
        else if (base >= O_LO && base <= O_HI)     up = CH_O;
        else if (base >= U_LO && base <= U_HI)     up = CH_U;
        else if (base == Y_ACU)                    up = CH_Y;
        else                                       hit = 1'b0;
        priority if (c == Y_DIA) res = CH_LOW_Y;
        else if (!hit)           res = c;
        else if (base == c)      res = up;
        else                     res = up + CASE_OFS;
        return res;
    endfunction

    rtcc_pkg::t_entry w_word;
    logic             w_in_win;

    assign w_word   = i_byp_en ? i_byp : i_rd;
    assign w_in_win = i_ctl.active && (i_code[rtcc_pkg::CODE_W-1:IDX_W] == i_block);

    always_comb begin
        priority if (!w_in_win)              o_mapped = i_code;
        else if (w_word.tag == i_ctl.epoch)  o_mapped = w_word.value;
        else if (i_ctl.preset)               o_mapped = f_preset(i_code);
        else                                 o_mapped = i_code;
    end

endmodule

@@ rtl/reorder_table_collation_compare_unit.sv @@
// path: a transaction is accepted into the input register, then its status is registered in the result register
// throughput: one transaction per cycle unless the receiver stalls, set by the single registered pass through the
//   two-read-port table memory; a window open that exhausts the epoch tags waits for a sweep
// reset: synchronous active low; a clearing sweep of all WINDOW_ENTRIES entries follows reset,
//   the 255th window open after reset and every 254th open after that; no input meanwhile
// ---------------------------------------------------------------------------
// reorder_table_collation_compare_unit
// collation compare of one code pair per transaction with a windowed remap table
// ---------------------------------------------------------------------------
`include "reorder_table_collation_compare_unit_defines.svh"

module reorder_table_collation_compare_unit #(
    parameter int WINDOW_ENTRIES = rtcc_pkg::WINDOW_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  rtcc_pkg::t_action i_action,
    input  rtcc_pkg::t_code   i_code_a,
    input  rtcc_pkg::t_code   i_code_b,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output rtcc_pkg::t_status o_status
);

    // window entries must be a power of two: index is the low code bits
    localparam int IDX_W = $clog2(WINDOW_ENTRIES);
    localparam int BLK_W = rtcc_pkg::CODE_W - IDX_W;

    // window state; entries carry an epoch tag so opening a window is a counter bump
    logic             r_active;
    logic             r_preset;
    logic [BLK_W-1:0] r_block;
    rtcc_pkg::t_epoch r_epoch;

    // input register stage
    logic              r_s1_valid;
    rtcc_pkg::t_action r_s1_action;
    rtcc_pkg::t_code   r_s1_code_a;
    rtcc_pkg::t_code   r_s1_code_b;

    // forwarding of a table write that lands on the same edge as the read
    logic             r_byp_a;
    logic             r_byp_b;
    rtcc_pkg::t_entry r_byp_word;

    // result register
    logic              r_out_valid;
    rtcc_pkg::t_status r_status;

    // next values
    logic              n_active;
    logic              n_preset;
    logic [BLK_W-1:0]  n_block;
    rtcc_pkg::t_epoch  n_epoch;
    rtcc_pkg::t_status n_status;
    logic              n_wr_en;

    logic              w_busy;
    logic              w_opens;
    logic              w_wrap;
    logic              w_adv;
    logic              w_acc;
    logic              w_tbl_we;
    logic [IDX_W-1:0]  w_wr_idx;
    rtcc_pkg::t_entry  w_wr_word;
    rtcc_pkg::t_entry  w_rd_a;
    rtcc_pkg::t_entry  w_rd_b;
    rtcc_pkg::t_code   w_map_a;
    rtcc_pkg::t_code   w_map_b;
    rtcc_pkg::t_map_ctl w_ctl;

    // an open bumps the epoch; at the last epoch the table is swept first
    assign w_opens = (r_s1_action == rtcc_pkg::ACT_SET_WINDOW)
                  || (r_s1_action == rtcc_pkg::ACT_PRESET)
                  || ((r_s1_action == rtcc_pkg::ACT_WRITE) && !r_active);
    assign w_wrap  = r_s1_valid && w_opens && (r_epoch == rtcc_pkg::EPOCH_MAX);

    // the item in the input register moves to the result register
    assign w_adv   = r_s1_valid && !w_busy && !w_wrap && (!r_out_valid || !i_stall);
    assign o_stall = w_busy || (r_s1_valid && !w_adv);
    assign w_acc   = i_valid && !o_stall;

    assign w_ctl = '{active: r_active, preset: r_preset, epoch: r_epoch};

    rtcc_table #(
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear_req (w_wrap),
        .o_busy      (w_busy),
        .i_we        (w_tbl_we),
        .i_wr_idx    (w_wr_idx),
        .i_wr_entry  (w_wr_word),
        .i_rd_en     (w_acc),
        .i_rd_idx_a  (i_code_a[IDX_W-1:0]),
        .i_rd_idx_b  (i_code_b[IDX_W-1:0]),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    rtcc_map #(
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_map_a (
        .i_code   (r_s1_code_a),
        .i_ctl    (w_ctl),
        .i_block  (r_block),
        .i_rd     (w_rd_a),
        .i_byp_en (r_byp_a),
        .i_byp    (r_byp_word),
        .o_mapped (w_map_a)
    );

    rtcc_map #(
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_map_b (
        .i_code   (r_s1_code_b),
        .i_ctl    (w_ctl),
        .i_block  (r_block),
        .i_rd     (w_rd_b),
        .i_byp_en (r_byp_b),
        .i_byp    (r_byp_word),
        .o_mapped (w_map_b)
    );

    // action decode and state update for the item in the input register
    always_comb begin
        n_active = r_active;
        n_preset = r_preset;
        n_block  = r_block;
        n_epoch  = r_epoch;
        n_status = rtcc_pkg::ST_OK;
        n_wr_en  = 1'b0;
        unique case (r_s1_action)
            rtcc_pkg::ACT_COMPARE: begin
                // mapped order first, raw order breaks the tie, shared nul ends the string
                priority if (w_map_a < w_map_b)         n_status = rtcc_pkg::ST_LESS;
                else if (w_map_a > w_map_b)             n_status = rtcc_pkg::ST_GREATER;
                else if (r_s1_code_a < r_s1_code_b)     n_status = rtcc_pkg::ST_LESS;
                else if (r_s1_code_a > r_s1_code_b)     n_status = rtcc_pkg::ST_GREATER;
                else if (r_s1_code_a == '0)             n_status = rtcc_pkg::ST_EQUAL;
                else                                    n_status = rtcc_pkg::ST_OK;
            end
            rtcc_pkg::ACT_WRITE: begin
                if (!r_active) begin
                    // disabled table opens the window holding the code first
                    n_active = 1'b1;
                    n_preset = 1'b0;
                    n_block  = r_s1_code_a[rtcc_pkg::CODE_W-1:IDX_W];
                    n_epoch  = r_epoch + 1'b1;
                    n_wr_en  = 1'b1;
                end else if (r_s1_code_a[rtcc_pkg::CODE_W-1:IDX_W] == r_block) begin
                    n_wr_en  = 1'b1;
                end else begin
                    n_status = rtcc_pkg::ST_RANGE;
                end
            end
            rtcc_pkg::ACT_SET_WINDOW: begin
                n_active = 1'b1;
                n_preset = 1'b0;
                n_block  = r_s1_code_a[rtcc_pkg::CODE_W-1:IDX_W];
                n_epoch  = r_epoch + 1'b1;
            end
            rtcc_pkg::ACT_DISABLE: begin
                n_active = 1'b0;
                n_preset = 1'b0;
            end
            rtcc_pkg::ACT_PRESET: begin
                n_active = 1'b1;
                n_preset = 1'b1;
                n_block  = '0;
                n_epoch  = r_epoch + 1'b1;
            end
            default: begin
                n_status = rtcc_pkg::ST_OK;
            end
        endcase
    end

    // entries are written with the epoch that is live after this transaction
    assign w_tbl_we  = w_adv && n_wr_en;
    assign w_wr_idx  = r_s1_code_a[IDX_W-1:0];
    assign w_wr_word = '{tag: n_epoch, value: r_s1_code_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_preset    <= 1'b0;
            r_block     <= '0;
            r_epoch     <= rtcc_pkg::EPOCH_FIRST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_busy) begin
                // sweep leaves every tag at zero, restart the epoch count
                r_epoch <= rtcc_pkg::EPOCH_FIRST;
            end else if (w_adv) begin
                r_epoch <= n_epoch;
            end
            if (w_adv) begin
                r_active <= n_active;
                r_preset <= n_preset;
                r_block  <= n_block;
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_action <= i_action;
            r_s1_code_a <= i_code_a;
            r_s1_code_b <= i_code_b;
            r_byp_a     <= w_tbl_we && (w_wr_idx == i_code_a[IDX_W-1:0]);
            r_byp_b     <= w_tbl_we && (w_wr_idx == i_code_b[IDX_W-1:0]);
            r_byp_word  <= w_wr_word;
        end
        if (w_adv) begin
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;

    // each window open advances the epoch by exactly one
    `RTCC_ASSERT_NEXT(a_epoch_step, w_adv && w_opens, r_epoch == rtcc_pkg::t_epoch'($past(r_epoch) + 1'b1), "epoch did not advance on window open")
    // disable drops both the table and the preset
    `RTCC_ASSERT_NEXT(a_disable_clears, w_adv && (r_s1_action == rtcc_pkg::ACT_DISABLE), !r_active && !r_preset, "disable left table state active")
    // the preset only lives in an active window at block zero
    `RTCC_ASSERT_SAME(a_preset_window, r_preset, r_active && (r_block == '0), "preset active outside window zero")
    // a stalled result stays put
    `RTCC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status), "result changed while stalled")

endmodule

@@ tb/sv/reorder_table_collation_compare_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reorder_table_collation_compare_unit_test
// self-checking bench for the collation compare unit: directed corner cases,
// then weighted random action streams, both channels idled and stalled at
// random, every status checked in order against a local model of the table
// ---------------------------------------------------------------------------
module reorder_table_collation_compare_unit_test;

    // bench timing
    localparam int   HALF_PERIOD  = 2;
    localparam int   RESET_CYCLES = 10;
    localparam int   RANDOM_ITEMS = 1125;
    // watchdog: the clearing sweep after reset plus the long receiver
    // hold-off plus the longest gaps, taken several times over
    localparam int   STUCK_LIMIT  = 8000;
    localparam int   LONG_HOLD    = 300;
    localparam int   HOLD_AT      = 450;
    localparam int   PAUSE_AT     = 800;
    localparam int   DRAIN_CYCLES = 8;

    // highest code the bench drives and the actions the block leaves alone
    localparam rtcc_pkg::t_code   CODE_MAX      = 21'h10FFFF;
    localparam rtcc_pkg::t_action ACT_UNUSED_LO = 3'd5;
    localparam rtcc_pkg::t_action ACT_UNUSED_HI = 3'd7;

    // -----------------------------------------------------------------------
    // table model and the queue of statuses still owed by the block
    // -----------------------------------------------------------------------
    class collation_scoreboard;
        rtcc_pkg::t_code   remap_value [rtcc_pkg::WINDOW_ENTRIES];
        bit                remap_set   [rtcc_pkg::WINDOW_ENTRIES];
        int unsigned       window_block;
        bit                table_on;
        bit                preset_on;
        rtcc_pkg::t_status status_q [$];
        int                mismatches;
        int                checked;

        function int unsigned block_of(rtcc_pkg::t_code c);
            return c / rtcc_pkg::WINDOW_ENTRIES;
        endfunction

        // latin-1 accented letter to its base letter, case kept
        function rtcc_pkg::t_code latin1_fold(rtcc_pkg::t_code c);
            rtcc_pkg::t_code base;
            rtcc_pkg::t_code up;
            if (c == 255)
                return rtcc_pkg::t_code'("y");
            base = (c >= 224 && c <= 253) ? rtcc_pkg::t_code'(c - 32) : c;
            if (base >= 192 && base <= 198) up = rtcc_pkg::t_code'("A");
            else if (base == 199) up = rtcc_pkg::t_code'("C");
            else if (base >= 200 && base <= 203) up = rtcc_pkg::t_code'("E");
            else if (base >= 204 && base <= 207) up = rtcc_pkg::t_code'("I");
            else if (base == 209) up = rtcc_pkg::t_code'("N");
            else if (base >= 210 && base <= 214) up = rtcc_pkg::t_code'("O");
            else if (base >= 217 && base <= 220) up = rtcc_pkg::t_code'("U");
            else if (base == 221) up = rtcc_pkg::t_code'("Y");
            else return c;
            return (base == c) ? up : rtcc_pkg::t_code'(up + 32);
        endfunction

        function rtcc_pkg::t_code map_code(rtcc_pkg::t_code c);
            int unsigned idx;
            if (block_of(c) != window_block)
                return c;
            idx = c % rtcc_pkg::WINDOW_ENTRIES;
            if (remap_set[idx])
                return remap_value[idx];
            if (preset_on)
                return latin1_fold(c);
            return c;
        endfunction

        function void open_window(rtcc_pkg::t_code start, bit preset);
            window_block = block_of(start);
            foreach (remap_set[i])
                remap_set[i] = 1'b0;
            table_on  = 1'b1;
            preset_on = preset;
        endfunction

        function rtcc_pkg::t_status predict_status(rtcc_pkg::t_action act,
                                                   rtcc_pkg::t_code a,
                                                   rtcc_pkg::t_code b);
            rtcc_pkg::t_code ma;
            rtcc_pkg::t_code mb;
            ma = a;
            mb = b;
            case (act)
                rtcc_pkg::ACT_COMPARE: begin
                    if (table_on) begin
                        ma = map_code(a);
                        mb = map_code(b);
                    end
                    if (ma < mb) return rtcc_pkg::ST_LESS;
                    if (ma > mb) return rtcc_pkg::ST_GREATER;
                    if (a < b) return rtcc_pkg::ST_LESS;
                    if (a > b) return rtcc_pkg::ST_GREATER;
                    return (a == 0) ? rtcc_pkg::ST_EQUAL : rtcc_pkg::ST_OK;
                end
                rtcc_pkg::ACT_WRITE: begin
                    if (!table_on)
                        open_window(a, 1'b0);
                    if (block_of(a) != window_block)
                        return rtcc_pkg::ST_RANGE;
                    remap_value[a % rtcc_pkg::WINDOW_ENTRIES] = b;
                    remap_set[a % rtcc_pkg::WINDOW_ENTRIES]   = 1'b1;
                end
                rtcc_pkg::ACT_SET_WINDOW: open_window(a, 1'b0);
                rtcc_pkg::ACT_DISABLE: begin
                    table_on  = 1'b0;
                    preset_on = 1'b0;
                end
                rtcc_pkg::ACT_PRESET: open_window('0, 1'b1);
                default: ;
            endcase
            return rtcc_pkg::ST_OK;
        endfunction

        function void note_transaction(rtcc_pkg::t_action act, rtcc_pkg::t_code a,
                                       rtcc_pkg::t_code b);
            status_q.push_back(predict_status(act, a, b));
        endfunction

        function void check_status(rtcc_pkg::t_status st);
            rtcc_pkg::t_status want;
            checked++;
            if (status_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected status, expected none, got %0d", $time, st);
                return;
            end
            want = status_q.pop_front();
            if (st !== want) begin
                mismatches++;
                $display("%0t: status mismatch, expected %0d, got %0d", $time, want, st);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // block and its wiring
    // -----------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    rtcc_pkg::t_action i_action;
    rtcc_pkg::t_code   i_code_a;
    rtcc_pkg::t_code   i_code_b;
    logic              o_valid;
    logic              i_stall;
    rtcc_pkg::t_status o_status;

    collation_scoreboard book;
    int                  burst_left;
    int                  stuck_cycles;

    reorder_table_collation_compare_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_code_a (i_code_a),
        .i_code_b (i_code_b),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // monitors and watchdog, all sampling pre-edge values at the rising edge
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // result side first, then the transaction taken at this edge
            if (o_valid && !i_stall)
                book.check_status(o_status);
            if (i_valid && !o_stall)
                book.note_transaction(i_action, i_code_a, i_code_b);
            // nothing moved on either side: count toward the limit
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // idle length for either side: mostly none, some short, a few long
    // -----------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // -----------------------------------------------------------------------
    // receiver: random stall stretches, one long hold-off once the run is
    // well under way so the block backs up into its input
    // -----------------------------------------------------------------------
    initial begin
        int run;
        int gap;
        bit held;
        held = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            // open stretch, sometimes long enough to run at full rate
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            if (!held && book.checked >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = idle_length();
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // sender: one transaction, held until the block takes it
    // -----------------------------------------------------------------------
    task automatic send(rtcc_pkg::t_action act, rtcc_pkg::t_code a, rtcc_pkg::t_code b);
        int gap;
        // bursts with no gaps at all, otherwise a random gap
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(20, 80);
            gap = 0;
        end else begin
            gap = idle_length();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_code_a <= a;
        i_code_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // drop valid and wait until the block owes nothing
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (book.status_q.size() != 0);
    endtask

    // random code anywhere from zero to CODE_MAX
    function automatic rtcc_pkg::t_code any_code();
        return rtcc_pkg::t_code'($urandom_range(0, CODE_MAX));
    endfunction

    // code mix: latin-1 range, inside the current window, anywhere, nul, CODE_MAX
    function automatic rtcc_pkg::t_code pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return rtcc_pkg::t_code'($urandom_range(0, 255));
        if (r < 60)
            return rtcc_pkg::t_code'(book.window_block * rtcc_pkg::WINDOW_ENTRIES
                                     + $urandom_range(0, 1023));
        if (r < 90) return any_code();
        if (r < 95) return '0;
        return CODE_MAX;
    endfunction

    // weighted random transaction, mostly compares against a live table
    task automatic send_random();
        int              r;
        rtcc_pkg::t_code a;
        rtcc_pkg::t_code b;
        r = $urandom_range(0, 99);
        a = pick_code();
        if (r < 70) begin
            // compare: ties, near misses and unrelated pairs
            case ($urandom_range(0, 9))
                0, 1, 2: b = a;
                3:       b = (a == CODE_MAX) ? a - 1'b1 : a + 1'b1;
                4:       b = (a == '0) ? a : a - 1'b1;
                default: b = pick_code();
            endcase
            send(rtcc_pkg::ACT_COMPARE, a, b);
        end else if (r < 87) begin
            // write: mostly inside the window, value small or anywhere
            if (book.table_on && $urandom_range(0, 99) < 85)
                a = rtcc_pkg::t_code'(book.window_block * rtcc_pkg::WINDOW_ENTRIES
                                      + $urandom_range(0, 1023));
            b = ($urandom_range(0, 1) == 0) ? rtcc_pkg::t_code'($urandom_range(0, 300))
                                            : any_code();
            send(rtcc_pkg::ACT_WRITE, a, b);
        end else if (r < 93) begin
            send(rtcc_pkg::ACT_SET_WINDOW, a, any_code());
        end else if (r < 96) begin
            send(rtcc_pkg::ACT_PRESET, a, any_code());
        end else if (r < 98) begin
            send(rtcc_pkg::ACT_DISABLE, a, any_code());
        end else begin
            send(rtcc_pkg::t_action'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), a,
                 any_code());
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        book         = new;
        burst_left   = 0;
        stuck_cycles = 0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_action <= rtcc_pkg::ACT_COMPARE;
        i_code_a <= '0;
        i_code_b <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // table disabled: raw compares, shared nul, code extremes
        send(rtcc_pkg::ACT_COMPARE, '0, '0);
        send(rtcc_pkg::ACT_COMPARE, CODE_MAX, '0);
        send(rtcc_pkg::ACT_COMPARE, '0, CODE_MAX);
        send(rtcc_pkg::ACT_COMPARE, 21'd65, 21'd65);
        // unused actions change nothing
        for (int k = ACT_UNUSED_LO; k <= ACT_UNUSED_HI; k++)
            send(rtcc_pkg::t_action'(k), any_code(), any_code());

        // latin-1 preset: accented vs base letter, y with diaeresis, cases
        send(rtcc_pkg::ACT_PRESET, CODE_MAX, CODE_MAX);
        send(rtcc_pkg::ACT_COMPARE, 21'd192, 21'd65);
        send(rtcc_pkg::ACT_COMPARE, 21'd255, 21'd121);
        send(rtcc_pkg::ACT_COMPARE, 21'd233, 21'd201);
        send(rtcc_pkg::ACT_COMPARE, 21'd208, 21'd215);
        // written entry overrides the preset, write outside the window
        send(rtcc_pkg::ACT_WRITE, 21'd65, 21'd300);
        send(rtcc_pkg::ACT_COMPARE, 21'd65, 21'd66);
        send(rtcc_pkg::ACT_WRITE, 21'd2000, 21'd5);

        // disabled again: raw codes, then a write opens the top window
        send(rtcc_pkg::ACT_DISABLE, '0, '0);
        send(rtcc_pkg::ACT_COMPARE, 21'd192, 21'd65);
        send(rtcc_pkg::ACT_WRITE, CODE_MAX, '0);
        send(rtcc_pkg::ACT_COMPARE, CODE_MAX, 21'd1);
        send(rtcc_pkg::ACT_COMPARE, 21'h10FC00, 21'h0F0000);

        // unaligned window start, largest written value, a write outside
        send(rtcc_pkg::ACT_SET_WINDOW, 21'h0F1234, '0);
        send(rtcc_pkg::ACT_WRITE, 21'h0F1234, CODE_MAX);
        send(rtcc_pkg::ACT_COMPARE, 21'h0F1234, CODE_MAX);
        send(rtcc_pkg::ACT_COMPARE, 21'h0F0000, 21'h0F0000);
        send(rtcc_pkg::ACT_WRITE, '0, 21'd5);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one full pause with nothing owed
            if (n == PAUSE_AT)
                drain_results();
            send_random();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
